>>> hdl/pcrs_pkg.sv
`timescale 1ns / 1ps
package pcrs_pkg;

  localparam int SLOT_COUNT = 2;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_BYTES = 10;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_MSB = 16'h8000;
  localparam logic [8:0] TIMEOUT_NORMAL = 9'd300;
  localparam logic [8:0] TIMEOUT_BROWNOUT = 9'd200;

  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 168;

  typedef enum logic [2:0] {
    MODE_SCAN_SLOT = 3'd0,
    MODE_SCAN_END  = 3'd1,
    MODE_INCREMENT = 3'd2,
    MODE_SAVE      = 3'd3,
    MODE_WRITE_DONE = 3'd4,
    MODE_BROWNOUT  = 3'd5,
    MODE_SERVICE   = 3'd6,
    MODE_QUERY     = 3'd7
  } mode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic crc_last;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // remainder update for one more nibble, msb first
  function automatic logic [SLOT_W-1:0] mod_step(input logic [SLOT_W-1:0] rem,
                                                 input logic [3:0] nib);
    logic [SLOT_W+3:0] v;
    logic [SLOT_W+3:0] k;
    v = {rem, nib};
    k = (SLOT_W + 4)'(SLOT_COUNT);
    for (int i = 3; i >= 0; i--) begin
      if (v >= (k << i)) begin
        v = v - (k << i);
      end
    end
    return v[SLOT_W-1:0];
  endfunction

endpackage

>>> hdl/pcrs_ctrl.sv
`timescale 1ns / 1ps
module pcrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pcrs_pkg::stat_t stat,
  output pcrs_pkg::cmd_t  cmd
);
  import pcrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CRC  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_CRC;
      S_CRC:  if (stat.crc_last) state_nxt = S_DONE;
      S_DONE: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cmd.load   = in_tready && in_tvalid;
  assign cmd.step   = (state_r == S_CRC);
  assign cmd.commit = (state_r == S_DONE) && stat.out_free;

endmodule

>>> hdl/pcrs_datapath.sv
`timescale 1ns / 1ps
module pcrs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcrs_pkg::cmd_t                cmd,
  output pcrs_pkg::stat_t               stat,
  input  logic [2:0]                    in_mode,
  input  logic [pcrs_pkg::IN_DATA_W-1:0] in_data,
  input  logic [11:0]                   base_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcrs_pkg::OUT_DATA_W-1:0] out_data
);
  import pcrs_pkg::*;

  mode_t       mode_r;
  logic [31:0] seq_in_r;
  logic [31:0] cnt_in_r;
  logic [15:0] chk_r;
  logic        rd_ok_r;
  logic        wr_ok_r;
  logic [63:0] op_r;
  logic [15:0] crc_r;
  logic [2:0]  idx_r;
  logic [31:0] next_seq_r;
  logic [31:0] mod_sh_r;
  logic [SLOT_W-1:0] slot_r;

  logic [31:0] committed_r, committed_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] pending_r, pending_nxt;
  logic [31:0] newest_seq_r, newest_seq_nxt;
  logic [31:0] best_cnt_r, best_cnt_nxt;
  logic        best_found_r, best_found_nxt;
  logic        save_pending_r, save_pending_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [31:0] ld_seq;
  logic [31:0] ld_cnt;
  logic [31:0] ld_next;
  logic        valid;
  logic        wreq;
  logic [8:0]  tmo;
  logic [12:0] waddr;
  logic [31:0] rec_cnt;

  // operands of the crc: the incoming record for a scan, else the record to write
  always_comb begin
    ld_seq = in_data[31:0];
    ld_cnt = in_data[63:32];
    if (mode_t'(in_mode) == MODE_SCAN_END && !best_found_r) begin
      ld_next = 32'd1;
    end else begin
      ld_next = committed_r + 32'd1;
    end
    if (mode_t'(in_mode) != MODE_SCAN_SLOT) begin
      ld_seq = ld_next;
      ld_cnt = (mode_t'(in_mode) == MODE_SCAN_END) ? 32'd0 : count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= mode_t'(in_mode);
      seq_in_r   <= in_data[31:0];
      cnt_in_r   <= in_data[63:32];
      chk_r      <= in_data[79:64];
      rd_ok_r    <= in_data[80];
      wr_ok_r    <= in_data[81];
      op_r       <= {ld_cnt, ld_seq};
      crc_r      <= CRC_INIT;
      next_seq_r <= ld_next;
      mod_sh_r   <= ld_next;
      slot_r     <= '0;
    end else if (cmd.step) begin
      op_r     <= {8'h00, op_r[63:8]};
      crc_r    <= crc_byte(crc_r, op_r[7:0]);
      mod_sh_r <= {mod_sh_r[27:0], 4'h0};
      slot_r   <= mod_step(slot_r, mod_sh_r[31:28]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  assign stat.crc_last = (idx_r == 3'd7);
  assign stat.out_free = !out_valid_r || out_ready;

  assign valid   = rd_ok_r && (crc_r == chk_r);
  assign waddr   = {1'b0, base_address} + 13'(slot_r) * 13'(SLOT_BYTES);
  assign rec_cnt = (mode_r == MODE_SCAN_END) ? 32'd0 : count_r;

  always_comb begin
    committed_nxt    = committed_r;
    count_nxt        = count_r;
    pending_nxt      = pending_r;
    newest_seq_nxt   = newest_seq_r;
    best_cnt_nxt     = best_cnt_r;
    best_found_nxt   = best_found_r;
    save_pending_nxt = save_pending_r;
    wreq             = 1'b0;
    tmo              = TIMEOUT_NORMAL;
    unique case (mode_r)
      MODE_SCAN_SLOT: begin
        if (valid && (!best_found_r || seq_in_r > newest_seq_r)) begin
          newest_seq_nxt = seq_in_r;
          best_cnt_nxt   = cnt_in_r;
          best_found_nxt = 1'b1;
        end
      end
      MODE_SCAN_END: begin
        if (best_found_r) begin
          committed_nxt = newest_seq_r;
          count_nxt     = best_cnt_r;
        end else begin
          committed_nxt = 32'd0;
          count_nxt     = 32'd0;
          pending_nxt   = next_seq_r;
          wreq          = 1'b1;
        end
        best_found_nxt = 1'b0;
        newest_seq_nxt = 32'd0;
        best_cnt_nxt   = 32'd0;
      end
      MODE_INCREMENT: count_nxt = count_r + 32'd1;
      MODE_SAVE: begin
        pending_nxt = next_seq_r;
        wreq        = 1'b1;
      end
      MODE_WRITE_DONE: if (wr_ok_r) committed_nxt = pending_r;
      MODE_BROWNOUT: save_pending_nxt = 1'b1;
      MODE_SERVICE: begin
        if (save_pending_r) begin
          save_pending_nxt = 1'b0;
          pending_nxt      = next_seq_r;
          wreq             = 1'b1;
          tmo              = TIMEOUT_BROWNOUT;
        end
      end
      MODE_QUERY: ;
      default: ;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0] = wreq;
    if (wreq) begin
      out_data_nxt[13:1]   = waddr;
      out_data_nxt[45:14]  = next_seq_r;
      out_data_nxt[77:46]  = rec_cnt;
      out_data_nxt[93:78]  = crc_r;
      out_data_nxt[102:94] = tmo;
    end
    out_data_nxt[103]     = (mode_r == MODE_SCAN_SLOT) && valid;
    out_data_nxt[135:104] = count_nxt;
    out_data_nxt[167:136] = committed_nxt;
  end

  assign out_valid_nxt = cmd.commit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r    <= '0;
      count_r        <= '0;
      pending_r      <= '0;
      newest_seq_r   <= '0;
      best_cnt_r     <= '0;
      best_found_r   <= 1'b0;
      save_pending_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        committed_r    <= committed_nxt;
        count_r        <= count_nxt;
        pending_r      <= pending_nxt;
        newest_seq_r   <= newest_seq_nxt;
        best_cnt_r     <= best_cnt_nxt;
        best_found_r   <= best_found_nxt;
        save_pending_r <= save_pending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/pingpong_counter_record_store_core.sv
`timescale 1ns / 1ps
// an input beat is loaded, then the byte-serial crc unit runs 8 steps, then the result
// is committed to the output register once it is free; no new beat is taken meanwhile
// the next input beat is taken while a finished result still waits in the output register
// reset: synchronous, active low; clears counter, sequences, scan tracker,
// brownout flag and base_address
module pingpong_counter_record_store_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[2:0]
  input  logic [7:0]  in_tuser,
  // slot_sequence[31:0], slot_count_value[63:32], slot_checksum[79:64],
  // read_ok[80], write_ok[81], zero[87:82]
  input  logic [pcrs_pkg::IN_DATA_W-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_request[0], write_address[13:1], record_sequence[45:14],
  // record_count[77:46], record_checksum[93:78], write_timeout_ms[102:94],
  // slot_valid[103], current_count[135:104], current_sequence[167:136]
  output logic [pcrs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pcrs_pkg::*;

  localparam logic [2:0] ADDR_BASE = 3'd0;

  cmd_t        cmd;
  stat_t       stat;
  logic [11:0] base_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_BASE) ? {20'h00000, base_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_BASE) begin
      base_r <= cfg_pwdata[11:0];
    end
  end

  pcrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcrs_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (in_tuser[2:0]),
    .in_data      (in_tdata),
    .base_address (base_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[102:1] == '0))
    else $error("record fields set without a write request");

  a_timeout_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |->
      (out_tdata[102:94] == TIMEOUT_NORMAL || out_tdata[102:94] == TIMEOUT_BROWNOUT))
    else $error("bad write timeout");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");

endmodule

>>> tb/pingpong_counter_record_store_core_test.sv
`timescale 1ns / 1ps
module pingpong_counter_record_store_core_test;
  import pcrs_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 150;
  localparam int CALM_LO = 200;
  localparam int CALM_HI = 280;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [2:0] BASE_ADDR_REG = 3'd0;

  typedef struct {
    mode_t       mode;
    logic [87:0] data;
  } in_beat_t;

  typedef struct {
    logic        write_req;
    logic [12:0] addr;
    logic [31:0] rec_seq;
    logic [31:0] rec_cnt;
    logic [15:0] rec_crc;
    logic [8:0]  timeout;
    logic        slot_ok;
    logic [31:0] cur_cnt;
    logic [31:0] cur_seq;
  } reply_t;

  class counter_store_scoreboard;
    logic [11:0] base_addr;
    logic [31:0] committed_seq;
    logic [31:0] counter;
    logic [31:0] pending_seq;
    logic [31:0] newest_seq;
    logic [31:0] best_cnt;
    bit          best_found;
    bit          brownout_pending;
    reply_t      expected_replies[$];
    int          errors;

    function new();
      base_addr = '0;
      committed_seq = '0;
      counter = '0;
      pending_seq = '0;
      newest_seq = '0;
      best_cnt = '0;
      best_found = 0;
      brownout_pending = 0;
      errors = 0;
    endfunction

    // crc-16/ccitt-false over seq then count, each little-endian, bit by bit
    function logic [15:0] record_crc(logic [31:0] seq, logic [31:0] cnt);
      logic [63:0] msg;
      logic [15:0] r;
      msg = {seq[7:0], seq[15:8], seq[23:16], seq[31:24],
             cnt[7:0], cnt[15:8], cnt[23:16], cnt[31:24]};
      r = CRC_INIT;
      for (int i = 63; i >= 0; i--) begin
        if (r[15] ^ msg[i]) begin
          r = {r[14:0], 1'b0} ^ CRC_POLY;
        end else begin
          r = {r[14:0], 1'b0};
        end
      end
      return r;
    endfunction

    function void request_record(inout reply_t r, input logic [8:0] tmo);
      logic [31:0] nxt;
      int unsigned slot;
      nxt = committed_seq + 32'd1;
      slot = nxt % SLOT_COUNT;
      pending_seq = nxt;
      r.write_req = 1'b1;
      r.addr = 13'(base_addr + slot * SLOT_BYTES);
      r.rec_seq = nxt;
      r.rec_cnt = counter;
      r.rec_crc = record_crc(nxt, counter);
      r.timeout = tmo;
    endfunction

    function void note_accepted_item(mode_t m, logic [87:0] d);
      reply_t r;
      logic [31:0] seq;
      logic [31:0] cnt;
      logic [15:0] chk;
      bit ok;
      seq = d[31:0];
      cnt = d[63:32];
      chk = d[79:64];
      r = '{default: '0};
      case (m)
        MODE_SCAN_SLOT: begin
          ok = d[80] && (record_crc(seq, cnt) == chk);
          if (ok && (!best_found || seq > newest_seq)) begin
            newest_seq = seq;
            best_cnt = cnt;
            best_found = 1;
          end
          r.slot_ok = ok;
        end
        MODE_SCAN_END: begin
          if (best_found) begin
            committed_seq = newest_seq;
            counter = best_cnt;
          end else begin
            committed_seq = '0;
            counter = '0;
            request_record(r, TIMEOUT_NORMAL);
          end
          best_found = 0;
          newest_seq = '0;
          best_cnt = '0;
        end
        MODE_INCREMENT: counter = counter + 32'd1;
        MODE_SAVE: request_record(r, TIMEOUT_NORMAL);
        MODE_WRITE_DONE: begin
          if (d[81]) committed_seq = pending_seq;
        end
        MODE_BROWNOUT: brownout_pending = 1;
        MODE_SERVICE: begin
          if (brownout_pending) begin
            brownout_pending = 0;
            request_record(r, TIMEOUT_BROWNOUT);
          end
        end
        default: ;
      endcase
      r.cur_cnt = counter;
      r.cur_seq = committed_seq;
      expected_replies.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] t);
      reply_t e;
      if (expected_replies.size() == 0) begin
        $error("result beat with nothing expected: %0h", t);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      compare("write_request", 32'(e.write_req), 32'(t[0]));
      compare("write_address", 32'(e.addr), 32'(t[13:1]));
      compare("record_sequence", e.rec_seq, t[45:14]);
      compare("record_count", e.rec_cnt, t[77:46]);
      compare("record_checksum", 32'(e.rec_crc), 32'(t[93:78]));
      compare("write_timeout_ms", 32'(e.timeout), 32'(t[102:94]));
      compare("slot_valid", 32'(e.slot_ok), 32'(t[103]));
      compare("current_count", e.cur_cnt, t[135:104]);
      compare("current_sequence", e.cur_seq, t[167:136]);
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [2:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  counter_store_scoreboard sb;
  in_beat_t plan[$];
  int items_sent;
  int results_seen;
  int hold_left;
  bit held_once;
  int idle_cycles;

  pingpong_counter_record_store_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: check every beat, random stalls, one long hold-off
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      sb.check_reply(out_tdata);
      results_seen++;
    end
    if (!held_once && results_seen == HOLD_AT) begin
      held_once = 1;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(input in_beat_t b);
    while (!(items_sent >= CALM_LO && items_sent < CALM_HI) && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {5'b0, b.mode};
    in_tdata <= b.data;
    do @(posedge clk); while (!in_tready);
    sb.note_accepted_item(b.mode, b.data);
    items_sent++;
  endtask

  task automatic run_plan();
    foreach (plan[i]) send_beat(plan[i]);
    in_tvalid <= 1'b0;
    plan.delete();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base_address(input logic [11:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= BASE_ADDR_REG;
    cfg_pwdata <= {20'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.base_addr = v;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {20'b0, v}) begin
      $error("base_address: expected %0h, got %0h", v, cfg_prdata);
      sb.errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_slot(input logic [31:0] seq, input logic [31:0] cnt,
                          input logic [15:0] chk, input bit rd);
    plan.push_back('{MODE_SCAN_SLOT, {6'b0, 1'($urandom_range(1)), rd, chk, cnt, seq}});
  endtask

  task automatic add_cmd(input mode_t m, input bit wr);
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    r[81] = wr;
    plan.push_back('{m, {6'b0, r[81:0]}});
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(15));
      3: return 32'hFFFF_FFFF - 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  task automatic add_scan_burst();
    logic [31:0] first;
    logic [31:0] seq;
    logic [31:0] cnt;
    logic [15:0] chk;
    bit rd;
    int n;
    n = SLOT_COUNT + (($urandom_range(3) == 0) ? 1 : 0);
    first = pick_word();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: seq = first;
        1: seq = first + 32'(i);
        default: seq = pick_word();
      endcase
      cnt = pick_word();
      chk = sb.record_crc(seq, cnt);
      rd = 1'b1;
      case ($urandom_range(9))
        0, 1: chk = chk ^ (16'h1 << $urandom_range(15));
        2: rd = 1'b0;
        3: seq = seq ^ (32'h1 << $urandom_range(31));
        default: ;
      endcase
      add_slot(seq, cnt, chk, rd);
    end
    if ($urandom_range(9) != 0) add_cmd(MODE_SCAN_END, $urandom_range(1));
  endtask

  task automatic add_random_items(input int n);
    logic [95:0] r;
    int k;
    while (plan.size() < n) begin
      k = $urandom_range(99);
      if (k < 25) begin
        add_scan_burst();
      end else if (k < 50) begin
        repeat ($urandom_range(1, 4)) add_cmd(MODE_INCREMENT, $urandom_range(1));
        add_cmd(MODE_SAVE, $urandom_range(1));
        add_cmd(MODE_WRITE_DONE, $urandom_range(9) < 8);
      end else if (k < 60) begin
        add_cmd(MODE_BROWNOUT, $urandom_range(1));
        if ($urandom_range(1)) add_cmd(MODE_INCREMENT, $urandom_range(1));
        add_cmd(MODE_SERVICE, $urandom_range(1));
        add_cmd(MODE_WRITE_DONE, $urandom_range(9) < 8);
      end else if (k < 70) begin
        add_cmd(MODE_SAVE, $urandom_range(1));
        add_cmd(MODE_SAVE, $urandom_range(1));
        add_cmd(MODE_WRITE_DONE, $urandom_range(1));
      end else if (k < 80) begin
        add_cmd($urandom_range(1) ? MODE_QUERY : MODE_SERVICE, $urandom_range(1));
      end else begin
        r = {$urandom(), $urandom(), $urandom()};
        plan.push_back('{mode_t'($urandom_range(7)), {6'b0, r[81:0]}});
      end
    end
  endtask

  task automatic add_directed_items();
    add_cmd(MODE_QUERY, 1'b0);
    add_cmd(MODE_SCAN_END, 1'b0);
    add_cmd(MODE_WRITE_DONE, 1'b1);
    add_slot(32'hFFFF_FFFF, 32'hFFFF_FFFF, sb.record_crc(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1);
    add_slot(32'd5, 32'd7, sb.record_crc(32'd5, 32'd7), 1'b1);
    // same sequence again must not replace the best record
    add_slot(32'hFFFF_FFFF, 32'h0, sb.record_crc(32'hFFFF_FFFF, 32'h0), 1'b1);
    add_slot(32'h0, 32'h0, sb.record_crc(32'h0, 32'h0) ^ 16'hFFFF, 1'b1);
    add_slot(32'hFFFF_FFFF, 32'h1234_5678, 16'h0000, 1'b1);
    add_slot(32'hFFFF_FFFF, 32'h1, sb.record_crc(32'hFFFF_FFFF, 32'h1), 1'b0);
    add_cmd(MODE_SCAN_END, 1'b1);
    add_cmd(MODE_INCREMENT, 1'b0);
    add_cmd(MODE_SAVE, 1'b0);
    add_cmd(MODE_WRITE_DONE, 1'b0);
    add_cmd(MODE_SAVE, 1'b1);
    add_cmd(MODE_SAVE, 1'b0);
    add_cmd(MODE_WRITE_DONE, 1'b1);
    add_cmd(MODE_WRITE_DONE, 1'b1);
    add_cmd(MODE_SERVICE, 1'b1);
    add_cmd(MODE_BROWNOUT, 1'b0);
    add_cmd(MODE_BROWNOUT, 1'b1);
    add_cmd(MODE_SERVICE, 1'b0);
    add_cmd(MODE_WRITE_DONE, 1'b1);
    add_slot(32'h0, 32'hFFFF_FFFF, sb.record_crc(32'h0, 32'hFFFF_FFFF), 1'b1);
    add_cmd(MODE_SCAN_END, 1'b0);
    add_cmd(MODE_QUERY, 1'b1);
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    results_seen = 0;
    hold_left = 0;
    held_once = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_base_address(12'hFFF);
    add_directed_items();
    run_plan();

    set_base_address(12'h000);
    add_random_items(140);
    run_plan();

    set_base_address(12'($urandom_range(4095)));
    add_random_items(130);
    run_plan();

    set_base_address(12'($urandom_range(4095)));
    add_random_items(130);
    run_plan();

    if (sb.outstanding() != 0) begin
      $error("%0d expected result beats never arrived", sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
